// ===== hdl/gbn_pkg.sv =====
// Shared types and constants for the go-back-N sender window.
// Depends on nothing; used by the controller, the datapath and the top level.
package gbn_pkg;

   localparam logic [1:0] KIND_SUBMIT = 2'd0;
   localparam logic [1:0] KIND_ACK    = 2'd1;
   localparam logic [1:0] KIND_TICK   = 2'd2;

   localparam logic [1:0] STATUS_FIRST   = 2'd0;
   localparam logic [1:0] STATUS_RESEND  = 2'd1;
   localparam logic [1:0] STATUS_REFUSED = 2'd2;

   localparam logic [15:0] TIMEOUT_RESET = 16'd300;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_EVAL  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_EMIT  = 5'b01000,
      ST_STALL = 5'b10000
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic take;      // capture the request
      logic eval;      // decide what the request does
      logic read;      // read slot or queue entry for the next result
      logic emit;      // present the result built from the read data
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic more;      // another result follows for this request
      logic any;       // the request produces at least one result
   } stat_type;

endpackage

// ===== hdl/gbn_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module gbn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== hdl/gbn_ctrl.sv =====
// Controller state machine of the go-back-N sender window.
// Depends on gbn_pkg.
module gbn_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  gbn_pkg::stat_type stat,
   output gbn_pkg::cmd_type  cmd
);
   gbn_pkg::state_type state_ff, state_in;

   assign req_tready = (state_ff == gbn_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == gbn_pkg::ST_STALL);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         gbn_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd.take = 1'b1;
               state_in = gbn_pkg::ST_EVAL;
            end
         end
         gbn_pkg::ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = gbn_pkg::ST_READ;
         end
         gbn_pkg::ST_READ: begin
            if (stat.any) begin
               cmd.read = 1'b1;
               state_in = gbn_pkg::ST_EMIT;
            end else begin
               state_in = gbn_pkg::ST_IDLE;
            end
         end
         gbn_pkg::ST_EMIT: begin
            cmd.emit = 1'b1;
            state_in = gbn_pkg::ST_STALL;
         end
         gbn_pkg::ST_STALL: begin
            if (rsp_tready) begin
               state_in = stat.more ? gbn_pkg::ST_READ : gbn_pkg::ST_IDLE;
            end
         end
         default: state_in = gbn_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gbn_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("controller state not one-hot");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("accept during result");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("result dropped");
endmodule

// ===== hdl/gbn_dp.sv =====
// Datapath of the go-back-N sender window: counters, slot store, wait queue.
// Depends on gbn_pkg and gbn_ram.
module gbn_dp #(
   parameter int WINDOW_SLOTS  = 8,
   parameter int WAITING_DEPTH = 16,
   parameter int MAX_PAYLOAD   = 121
) (
   input  logic              clock,
   input  logic              reset,
   input  gbn_pkg::cmd_type  cmd,
   output gbn_pkg::stat_type stat,
   input  logic [1:0]        kind,
   input  logic [15:0]       payload_handle,
   input  logic [6:0]        payload_length,
   input  logic [31:0]       ack_number,
   input  logic              ack_intact,
   input  logic              csr_valid,
   input  logic [15:0]       csr_data,
   output logic [1:0]        status,
   output logic [31:0]       sequence_number,
   output logic [15:0]       sent_handle,
   output logic [6:0]        sent_length,
   output logic              last
);
   localparam int SW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
   localparam int CW = $clog2(WINDOW_SLOTS + 1);
   localparam int QW = (WAITING_DEPTH > 1) ? $clog2(WAITING_DEPTH) : 1;
   localparam int QCW = $clog2(WAITING_DEPTH + 1);
   localparam logic [6:0] MAXLEN = 7'(MAX_PAYLOAD);
   localparam logic [CW-1:0] SLOTS = CW'(WINDOW_SLOTS);
   localparam logic [QCW-1:0] QDEPTH = QCW'(WAITING_DEPTH);

   typedef enum logic [1:0] { OP_NONE, OP_SEND, OP_REFILL, OP_RESEND } op_type;

   logic [15:0]    timeout_ff;
   logic [31:0]    next_seq_ff, oldest_ff, tick_ff;
   logic [CW-1:0]  inflight_ff;
   logic [QW-1:0]  qhead_ff;
   logic [QCW-1:0] qcount_ff;
   logic [1:0]     kind_ff;
   logic [15:0]    h_ff;
   logic [6:0]     len_ff;
   logic [31:0]    ack_ff;
   logic           intact_ff;
   op_type         op_ff;
   logic [CW-1:0]  cnt_ff;      // results still to emit
   logic [CW-1:0]  idx_ff;      // resend offset
   logic [1:0]     st_ff;
   logic [31:0]    seq_ff;
   logic [15:0]    oh_ff;
   logic [6:0]     ol_ff;
   logic           olast_ff;
   logic           tick_eval_ff; // waiting for oldest timestamp

   logic [6:0]  len_sat;
   logic [31:0] ack_off;
   logic [31:0] cur_seq;
   logic [22:0] slot_wdata, slot_rdata, q_rdata;
   logic [31:0] ts_rdata;
   logic        slot_we, ts_we, q_we;
   logic [SW-1:0] slot_waddr, slot_raddr, ts_waddr;
   logic [31:0] ts_wdata;
   logic [QW-1:0] q_waddr;
   logic        timeout_hit;

   assign len_sat = (payload_length > MAXLEN) ? MAXLEN : payload_length;
   assign ack_off = ack_ff - oldest_ff;

   // The oldest timestamp is on the read port in the cycle after eval.
   assign timeout_hit = tick_eval_ff && (tick_ff - ts_rdata >= 32'(timeout_ff));

   // Sequence of the result being prepared in ST_READ.
   assign cur_seq = (op_ff == OP_RESEND || tick_eval_ff) ? oldest_ff + 32'(idx_ff)
                                                         : oldest_ff + 32'(inflight_ff);

   assign stat.any  = (cnt_ff != '0) || timeout_hit;
   assign stat.more = (cnt_ff != '0);

   always_comb begin
      slot_raddr = cur_seq[SW-1:0];
      if (cmd.eval) slot_raddr = oldest_ff[SW-1:0];
   end

   // Slot writes at emit: a new send of a submit or a refill; a resend rewrites only the timestamp.
   always_comb begin
      slot_we = 1'b0; ts_we = 1'b0;
      slot_waddr = cur_seq[SW-1:0];
      ts_waddr = cur_seq[SW-1:0];
      slot_wdata = {h_ff, len_ff};
      ts_wdata = tick_ff;
      if (cmd.emit) begin
         case (op_ff)
            OP_SEND:   begin slot_we = 1'b1; ts_we = 1'b1; end
            OP_REFILL: begin
               slot_we = 1'b1; ts_we = 1'b1; slot_wdata = q_rdata;
            end
            OP_RESEND: ts_we = 1'b1;
            default: ;
         endcase
      end
   end

   assign q_we    = cmd.eval && (kind_ff == gbn_pkg::KIND_SUBMIT) && (len_ff != '0)
                    && !(inflight_ff < SLOTS && qcount_ff == '0) && (qcount_ff < QDEPTH);
   assign q_waddr = QW'((QCW'(qhead_ff) + qcount_ff) % QCW'(WAITING_DEPTH));

   gbn_ram #(.WIDTH(23), .DEPTH(WINDOW_SLOTS)) u_slot (
      .clock, .wr_en(slot_we), .wr_addr(slot_waddr), .wr_data(slot_wdata),
      .rd_addr(slot_raddr), .rd_data(slot_rdata));
   gbn_ram #(.WIDTH(32), .DEPTH(WINDOW_SLOTS)) u_ts (
      .clock, .wr_en(ts_we), .wr_addr(ts_waddr), .wr_data(ts_wdata),
      .rd_addr(slot_raddr), .rd_data(ts_rdata));
   gbn_ram #(.WIDTH(23), .DEPTH(WAITING_DEPTH)) u_q (
      .clock, .wr_en(q_we), .wr_addr(q_waddr), .wr_data({h_ff, len_ff}),
      .rd_addr(qhead_ff), .rd_data(q_rdata));

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         kind_ff <= kind; h_ff <= payload_handle; len_ff <= len_sat;
         ack_ff <= ack_number; intact_ff <= ack_intact;
      end
      if (cmd.emit) begin
         seq_ff <= (op_ff == OP_NONE) ? next_seq_ff : cur_seq;
         st_ff <= (op_ff == OP_RESEND) ? gbn_pkg::STATUS_RESEND
                : (op_ff == OP_NONE) ? gbn_pkg::STATUS_REFUSED : gbn_pkg::STATUS_FIRST;
         oh_ff <= (op_ff == OP_REFILL) ? q_rdata[22:7]
                : (op_ff == OP_RESEND) ? slot_rdata[22:7] : h_ff;
         ol_ff <= (op_ff == OP_REFILL) ? q_rdata[6:0]
                : (op_ff == OP_RESEND) ? slot_rdata[6:0] : len_ff;
         olast_ff <= (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= gbn_pkg::TIMEOUT_RESET;
         next_seq_ff <= '0; oldest_ff <= '0; tick_ff <= '0;
         inflight_ff <= '0; qhead_ff <= '0; qcount_ff <= '0;
         op_ff <= OP_NONE; cnt_ff <= '0; idx_ff <= '0; tick_eval_ff <= 1'b0;
      end else begin
         if (csr_valid) timeout_ff <= csr_data;
         if (cmd.take) begin
            cnt_ff <= '0; idx_ff <= '0; op_ff <= OP_NONE; tick_eval_ff <= 1'b0;
         end
         if (cmd.eval) begin
            case (kind_ff)
               gbn_pkg::KIND_SUBMIT: begin
                  if (len_ff != '0) begin
                     if (inflight_ff < SLOTS && qcount_ff == '0) begin
                        op_ff <= OP_SEND; cnt_ff <= CW'(1);
                        next_seq_ff <= next_seq_ff + 32'd1;
                     end else if (qcount_ff < QDEPTH) begin
                        qcount_ff <= qcount_ff + QCW'(1);
                        next_seq_ff <= next_seq_ff + 32'd1;
                     end else begin
                        op_ff <= OP_NONE; cnt_ff <= CW'(1);
                     end
                  end
               end
               gbn_pkg::KIND_ACK: begin
                  if (intact_ff && ack_off < 32'(inflight_ff)) begin
                     oldest_ff <= ack_ff + 32'd1;
                     inflight_ff <= inflight_ff - CW'(ack_off) - CW'(1);
                     op_ff <= OP_REFILL;
                     if (32'(SLOTS - (inflight_ff - CW'(ack_off) - CW'(1)))
                         < 32'(qcount_ff))
                        cnt_ff <= SLOTS - (inflight_ff - CW'(ack_off) - CW'(1));
                     else
                        cnt_ff <= CW'(qcount_ff);
                  end
               end
               gbn_pkg::KIND_TICK: begin
                  tick_ff <= tick_ff + 32'd1;
                  tick_eval_ff <= (inflight_ff != '0);
               end
               default: ;
            endcase
         end
         // Timestamp of the oldest slot is valid in the cycle after eval.
         if (tick_eval_ff) begin
            tick_eval_ff <= 1'b0;
            if (timeout_hit) begin
               op_ff <= OP_RESEND; cnt_ff <= inflight_ff;
            end
         end
         if (cmd.emit) begin
            cnt_ff <= cnt_ff - CW'(1);
            case (op_ff)
               OP_SEND: inflight_ff <= inflight_ff + CW'(1);
               OP_REFILL: begin
                  inflight_ff <= inflight_ff + CW'(1);
                  qhead_ff <= QW'((QCW'(qhead_ff) + QCW'(1)) % QCW'(WAITING_DEPTH));
                  qcount_ff <= qcount_ff - QCW'(1);
               end
               OP_RESEND: idx_ff <= idx_ff + CW'(1);
               default: ;
            endcase
         end
      end
   end

   assign status = st_ff;
   assign sequence_number = seq_ff;
   assign sent_handle = oh_ff;
   assign sent_length = ol_ff;
   assign last = olast_ff;

   a_window: assert property (@(posedge clock) disable iff (reset) inflight_ff <= SLOTS)
      else $error("window overfull");
   a_queue: assert property (@(posedge clock) disable iff (reset) qcount_ff <= QDEPTH)
      else $error("queue overfull");
   a_refill: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && op_ff == OP_REFILL |-> qcount_ff != '0) else $error("refill from empty");
endmodule

// ===== hdl/go_back_n_sender_window.sv =====
// Go-back-N sender window: top level joining the controller and the datapath.
// Depends on gbn_pkg, gbn_ctrl, gbn_dp and gbn_ram.
//
// One request transaction is taken at a time. A request is taken and
// evaluated, and then each result it causes goes through a slot or queue
// read, a result build and an output that holds while the receiver stalls.
// The request side is ready only while no result is pending. Results are one
// rsp transaction each, with tlast marking the final result of a request. The
// user must write the timeout register through the csr channel only while the
// block is idle; the block itself does not enforce this. The timeout is
// checked only when a tick request arrives.
module go_back_n_sender_window #(
   parameter int WINDOW_SLOTS  = 8,
   parameter int WAITING_DEPTH = 16,
   parameter int MAX_PAYLOAD   = 121
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // payload_handle[15:0], payload_length[22:16],
                                    // ack_number[54:23], ack_intact[55]
   input  logic [1:0]  req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // sequence_number[31:0], sent_handle[47:32],
                                    // sent_length[54:48], zero[55]
   output logic [1:0]  rsp_tuser,   // status
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);
   gbn_pkg::cmd_type  cmd;
   gbn_pkg::stat_type stat;
   logic [31:0] seq;
   logic [15:0] h;
   logic [6:0]  len;

   assign csr_ready = 1'b1;

   gbn_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .stat, .cmd);

   gbn_dp #(.WINDOW_SLOTS(WINDOW_SLOTS), .WAITING_DEPTH(WAITING_DEPTH),
            .MAX_PAYLOAD(MAX_PAYLOAD)) u_dp (
      .clock, .reset, .cmd, .stat,
      .kind(req_tuser), .payload_handle(req_tdata[15:0]),
      .payload_length(req_tdata[22:16]), .ack_number(req_tdata[54:23]),
      .ack_intact(req_tdata[55]), .csr_valid, .csr_data,
      .status(rsp_tuser), .sequence_number(seq), .sent_handle(h),
      .sent_length(len), .last(rsp_tlast));

   assign rsp_tdata = {1'b0, len, h, seq};
endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the go-back-N sender window.
// Depends on gbn_pkg and the go_back_n_sender_window RTL. It needs no other files.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS     = 8;
   localparam int QDEPTH    = 16;
   localparam int MAX_BYTES = 121;

   // Kind code that the block does not define and must ignore.
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // One packet that the block is expected to put out.
   typedef struct {
      logic [1:0]  status;
      logic [31:0] seq;
      logic [15:0] handle;
      logic [6:0]  length;
      logic        last;
   } sent_pkt_type;

   // This class models the window and the queue. It holds the packets that
   // should come out, in the order that they should come out.
   class sender_window_scoreboard;
      logic [15:0] timeout;
      logic [31:0] next_seq, oldest_unacked, tick;
      int          in_flight, q_head, q_count;
      logic [15:0] slot_handle [SLOTS];
      logic [6:0]  slot_length [SLOTS];
      logic [31:0] slot_tick   [SLOTS];
      logic [22:0] q_entry     [QDEPTH];
      sent_pkt_type pending_sends[$];
      int          errors, sent_seen, resends, refusals;

      function new();
         timeout = gbn_pkg::TIMEOUT_RESET;
         next_seq = 0; oldest_unacked = 0; tick = 0;
         in_flight = 0; q_head = 0; q_count = 0;
         errors = 0; sent_seen = 0; resends = 0; refusals = 0;
      endfunction

      function void push_sent(logic [1:0] st, logic [31:0] seq, logic [15:0] h,
                              logic [6:0] len);
         sent_pkt_type p;
         p.status = st; p.seq = seq; p.handle = h; p.length = len; p.last = 1'b0;
         pending_sends.push_back(p);
      endfunction

      function void launch(logic [15:0] h, logic [6:0] len);
         logic [31:0] seq;
         seq = oldest_unacked + in_flight;
         slot_handle[seq % SLOTS] = h;
         slot_length[seq % SLOTS] = len;
         slot_tick[seq % SLOTS]   = tick;
         in_flight++;
         push_sent(gbn_pkg::STATUS_FIRST, seq, h, len);
      endfunction

      // Works out the packets that one accepted request causes.
      function void predict_request(logic [1:0] kind, logic [15:0] h, logic [6:0] len,
                                    logic [31:0] ackn, logic intact);
         int          before_n;
         logic [31:0] off, seq;
         logic [22:0] e;
         before_n = pending_sends.size();
         if (kind == gbn_pkg::KIND_SUBMIT) begin
            if (len != 0) begin
               if (len > MAX_BYTES) len = 7'(MAX_BYTES);
               if (in_flight < SLOTS && q_count == 0) begin
                  launch(h, len);
                  next_seq++;
               end else if (q_count < QDEPTH) begin
                  q_entry[(q_head + q_count) % QDEPTH] = {h, len};
                  q_count++;
                  next_seq++;
               end else begin
                  push_sent(gbn_pkg::STATUS_REFUSED, next_seq, h, len);
                  refusals++;
               end
            end
         end else if (kind == gbn_pkg::KIND_ACK) begin
            off = ackn - oldest_unacked;
            if (intact && off < in_flight) begin
               oldest_unacked += off + 1;
               in_flight -= off + 1;
               while (in_flight < SLOTS && q_count > 0) begin
                  e = q_entry[q_head];
                  q_head = (q_head + 1) % QDEPTH;
                  q_count--;
                  launch(e[22:7], e[6:0]);
               end
            end
         end else if (kind == gbn_pkg::KIND_TICK) begin
            tick++;
            if (in_flight > 0 && tick - slot_tick[oldest_unacked % SLOTS] >= timeout) begin
               for (int i = 0; i < in_flight; i++) begin
                  seq = oldest_unacked + i;
                  slot_tick[seq % SLOTS] = tick;
                  push_sent(gbn_pkg::STATUS_RESEND, seq, slot_handle[seq % SLOTS],
                            slot_length[seq % SLOTS]);
                  resends++;
               end
            end
         end
         if (pending_sends.size() > before_n)
            pending_sends[pending_sends.size() - 1].last = 1'b1;
      endfunction

      function void check_sent(logic [1:0] st, logic [31:0] seq, logic [15:0] h,
                               logic [6:0] len, logic last);
         sent_pkt_type p;
         sent_seen++;
         if (pending_sends.size() == 0) begin
            $error("unexpected result: status %0d seq %0h", st, seq);
            errors++;
            return;
         end
         p = pending_sends.pop_front();
         if (st !== p.status) begin
            $error("status: expected %0d, got %0d", p.status, st); errors++;
         end
         if (seq !== p.seq) begin
            $error("sequence_number: expected %0h, got %0h", p.seq, seq); errors++;
         end
         if (h !== p.handle) begin
            $error("sent_handle: expected %0h, got %0h", p.handle, h); errors++;
         end
         if (len !== p.length) begin
            $error("sent_length: expected %0d, got %0d", p.length, len); errors++;
         end
         if (last !== p.last) begin
            $error("last: expected %0d, got %0d", p.last, last); errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;   // payload_handle, payload_length, ack_number, ack_intact
   logic [1:0]  req_tuser = gbn_pkg::KIND_TICK;   // kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;        // sequence_number, sent_handle, sent_length, zero
   logic [1:0]  rsp_tuser;        // status
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   sender_window_scoreboard sb = new();
   int items_sent = 0;

   always #5 clock = ~clock;

   go_back_n_sender_window dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // Mostly no gap or a short one, now and then a long one.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offers one request transaction and notes it in the scoreboard once it
   // has been accepted. Valid stays high straight into the next request when
   // no gap is drawn.
   task automatic send_req(logic [1:0] kind, logic [15:0] h, logic [6:0] len,
                           logic [31:0] ackn, logic intact);
      int g;
      g = gap_len();
      @(negedge clock);
      if (g > 0) begin
         req_tvalid = 1'b0;
         repeat (g) @(negedge clock);
      end
      req_tuser  = kind;
      req_tdata  = {intact, ackn, len, h};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.predict_request(kind, h, len, ackn, intact);
      items_sent++;
   endtask

   task automatic submit(logic [15:0] h, logic [6:0] len);
      send_req(gbn_pkg::KIND_SUBMIT, h, len, $urandom, 1'($urandom_range(0, 1)));
   endtask

   task automatic ack(logic [31:0] ackn, logic intact);
      send_req(gbn_pkg::KIND_ACK, 16'($urandom_range(0, 65535)),
               7'($urandom_range(0, 127)), ackn, intact);
   endtask

   task automatic tick();
      send_req(gbn_pkg::KIND_TICK, 16'($urandom_range(0, 65535)),
               7'($urandom_range(0, 127)), $urandom, 1'($urandom_range(0, 1)));
   endtask

   // Holds the sender back until every expected packet has come out, then
   // lets the block finish any request that causes no packet.
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending_sends.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Register write, only ever made while the block is idle.
   task automatic set_timeout(logic [15:0] value);
      drain();
      @(negedge clock);
      csr_data  = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.timeout = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // An acknowledgement that frees at least one packet when any is in flight.
   task automatic good_ack();
      if (sb.in_flight > 0)
         ack(sb.oldest_unacked + $urandom_range(0, sb.in_flight - 1), 1'b1);
      else
         ack(sb.oldest_unacked, 1'b1);
   endtask

   // Random traffic. submit_pct sets how hard the queue is pushed.
   task automatic random_phase(int count, int submit_pct);
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < submit_pct) begin
            r = $urandom_range(0, 99);
            if (r < 90)      submit(16'($urandom), 7'($urandom_range(1, MAX_BYTES)));
            else if (r < 95) submit(16'($urandom), 7'($urandom_range(MAX_BYTES + 1, 127)));
            else             submit(16'($urandom), 7'd0);
         end else if (r < submit_pct + 25) begin
            r = $urandom_range(0, 99);
            if (r < 75)      good_ack();
            else if (r < 85) ack(sb.oldest_unacked + $urandom_range(0, 3), 1'b0);
            else             ack($urandom, 1'($urandom_range(0, 1)));
         end else if (r < 97) begin
            tick();
         end else begin
            send_req(KIND_UNUSED, 16'($urandom), 7'($urandom_range(0, 127)), $urandom,
                     1'($urandom_range(0, 1)));
         end
      end
   endtask

   // The receiver stalls at random, with stretches where it never stalls.
   initial begin
      int g;
      forever begin
         @(negedge clock);
         rsp_tready = 1'b1;
         if ($urandom_range(0, 3) == 0) begin
            g = gap_len();
            if (g > 0) begin
               rsp_tready = 1'b0;
               repeat (g) @(negedge clock);
            end
         end
      end
   end

   // Every result transaction is checked against the oldest expected packet.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_sent(rsp_tuser, rsp_tdata[31:0], rsp_tdata[47:32], rsp_tdata[54:48],
                       rsp_tlast);
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part under the reset timeout: field extremes, the ignored
      // cases and saturation.
      submit(16'h0000, 7'd1);
      submit(16'hFFFF, 7'd121);
      submit(16'h1234, 7'd0);
      submit(16'hA5A5, 7'd127);
      send_req(KIND_UNUSED, 16'hFFFF, 7'd127, 32'hFFFF_FFFF, 1'b1);
      ack(32'd1, 1'b0);
      ack(32'hFFFF_FFFF, 1'b1);
      ack(32'd0, 1'b1);
      tick();
      for (int i = 0; i < 8; i++) submit(16'(16'h5A00 + i), 7'(7'd60 + i));
      ack(sb.oldest_unacked + 2, 1'b1);
      ack(sb.oldest_unacked + sb.in_flight + sb.q_count, 1'b1);
      tick();
      good_ack();

      // Timeout of one: every tick resends the window.
      set_timeout(16'd1);
      tick();
      tick();
      good_ack();
      tick();

      // Fill the queue until submits are refused.
      set_timeout(16'd65535);
      for (int i = 0; i < 26; i++)
         submit(16'($urandom), 7'($urandom_range(1, MAX_BYTES)));
      ack(sb.oldest_unacked + sb.in_flight - 1, 1'b1);

      set_timeout(16'd4);
      random_phase(110, 45);
      drain();   // sender waits here until all expected packets have come
      random_phase(40, 45);

      set_timeout(16'd65535);
      random_phase(100, 70);

      set_timeout(16'd0);
      random_phase(60, 40);

      set_timeout(16'd9);
      random_phase(90, 50);

      drain();
      if (sb.pending_sends.size() != 0) begin
         $error("%0d expected packets never came out", sb.pending_sends.size());
         sb.errors++;
      end
      $display("covered %0d requests and %0d packets (%0d resends, %0d refusals),",
               items_sent, sb.sent_seen, sb.resends, sb.refusals);
      $display("timeouts from 0 to 65535, queue overflow and ignored requests");
      if (sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #10ms;
      $display("status: fail");
      $finish;
   end

endmodule
